[hdl/gspe_pkg.sv]
// Package for the shortest-path engine: sizes, mode and state codes, result type.
// Used by the top level and the engine; depends on nothing.
package gspe_pkg;

  localparam int VERTICES      = 64;
  localparam int LOG_V         = $clog2(VERTICES);
  localparam int WEIGHT_BITS   = 16;
  localparam int DISTANCE_BITS = 32;
  localparam int EDGE_BITS     = WEIGHT_BITS + 1;
  localparam int EDGE_AW       = 2 * LOG_V;
  localparam int CNT_BITS      = EDGE_AW + 1;

  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 6;
  localparam int WIN_W    = 16;
  localparam int DOUT_W   = 32;

  localparam logic [DISTANCE_BITS-1:0] DMAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_VERTEX = 3'd0,
    MODE_ADD_EDGE   = 3'd1,
    MODE_RMV_EDGE   = 3'd2,
    MODE_RMV_VERTEX = 3'd3,
    MODE_WEIGHT     = 3'd4,
    MODE_DISTANCES  = 3'd5,
    MODE_PATH       = 3'd6
  } mode_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_WR,
    ST_RMV,
    ST_WQ_RES,
    ST_FAIL_RES,
    ST_FIND,
    ST_SETTLE,
    ST_RELAX,
    ST_D_RD,
    ST_D_OUT,
    ST_T_WR,
    ST_T_RD,
    ST_P_RD1,
    ST_P_RD2,
    ST_P_OUT
  } state_e;

  typedef struct packed {
    logic [SLOT_W-1:0] vertex;
    logic [DOUT_W-1:0] distance;
    logic              present;
    logic              found;
    logic              last;
  } res_t;

endpackage

[hdl/graph_shortest_path_engine_top.sv]
// Top level of the shortest-path engine: stream ports and the result register.
// Depends on gspe_pkg and gspe_engine.
//
// Usage: each input item on the slave stream is one command (add or remove a
// vertex or an edge, or an edge weight, all-distances or path query). The
// block takes one item at a time and holds s_axis_tready low while it works.
// A query runs Dijkstra over the edge memory: each round scans all slots
// twice (one slot a cycle through the single edge memory read port and the
// shared adder and comparator). A distances query returns 64 results, a path
// query one result per vertex on the path (or one when there is no path), a
// weight query one; tlast marks the final result of an item.
// Results pass through an output register, so the engine only pauses when
// that register is still full and m_axis_tready is low. After reset the edge
// memory is cleared, and no item is accepted until the clearing is done.
module graph_shortest_path_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode [2:0], first_vertex [8:3], second_vertex [14:9], weight [30:15]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // vertex [5:0], distance [37:6]
  output logic [39:0] m_axis_tdata,
  // present [0], found [1]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import gspe_pkg::*;

  logic res_valid, res_ready;
  res_t res, out_q;
  logic out_vld_q;

  assign res_ready = !out_vld_q || m_axis_tready;

  gspe_engine u_engine (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tdata[2:0]),
    .in_first_i  (s_axis_tdata[8:3]),
    .in_second_i (s_axis_tdata[14:9]),
    .in_weight_i (s_axis_tdata[30:15]),
    .in_ready_o  (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
      if (res_valid) out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.distance, out_q.vertex};
  assign m_axis_tuser  = {out_q.found, out_q.present};
  assign m_axis_tlast  = out_q.last;

endmodule

[hdl/gspe_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
// Generic; depends on nothing.
module gspe_ram #(
  parameter int DW = 8,
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/gspe_engine.sv]
// Sequencer and shared add/compare unit of the shortest-path engine, with the
// edge, distance, predecessor and path memories. Depends on gspe_pkg and gspe_ram.
module gspe_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [gspe_pkg::MODE_W-1:0] in_mode_i,
  input  logic [gspe_pkg::SLOT_W-1:0] in_first_i,
  input  logic [gspe_pkg::SLOT_W-1:0] in_second_i,
  input  logic [gspe_pkg::WIN_W-1:0]  in_weight_i,
  output logic                       in_ready_o,
  output logic                       res_valid_o,
  output gspe_pkg::res_t             res_o,
  input  logic                       res_ready_i
);
  import gspe_pkg::*;

  state_e state_q, state_d;

  logic [MODE_W-1:0]      mode_q;
  logic [SLOT_W-1:0]      a_q, b_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [CNT_BITS-1:0]    cnt_q;
  logic [VERTICES-1:0]    present_q, reached_q, settled_q;
  logic [LOG_V-1:0]       cur_q, pidx_q, curv_q, v_q, k_q;
  logic [DISTANCE_BITS-1:0] best_q;
  logic                   have_q, pv_q;

  logic                   edge_we;
  logic [EDGE_AW-1:0]     edge_waddr, edge_raddr;
  logic [EDGE_BITS-1:0]   edge_wdata, edge_rdata;
  logic                   dist_we;
  logic [LOG_V-1:0]       dist_waddr, dist_raddr;
  logic [DISTANCE_BITS-1:0] dist_wdata, dist_rdata;
  logic                   pred_we;
  logic [LOG_V-1:0]       pred_rdata;
  logic                   buf_we;
  logic [LOG_V-1:0]       buf_rdata;

  logic                   a_ok, b_ok, a_p, b_p;
  logic [LOG_V-1:0]       ai, bi, ci;
  logic [VERTICES-1:0]    a_bit, b_bit;
  logic                   scan_end, e_valid;
  logic [WEIGHT_BITS-1:0] e_w;
  logic [DISTANCE_BITS:0] sum;
  logic [DISTANCE_BITS-1:0] nd;
  logic                   relax_upd, find_upd;

  assign ai       = a_q[LOG_V-1:0];
  assign bi       = b_q[LOG_V-1:0];
  assign ci       = cnt_q[LOG_V-1:0];
  assign a_bit    = {{(VERTICES-1){1'b0}}, 1'b1} << ai;
  assign b_bit    = {{(VERTICES-1){1'b0}}, 1'b1} << bi;
  assign a_ok     = 32'(a_q) < VERTICES;
  assign b_ok     = 32'(b_q) < VERTICES;
  assign a_p      = a_ok && present_q[ai];
  assign b_p      = b_ok && present_q[bi];
  assign scan_end = cnt_q == CNT_BITS'(VERTICES);
  assign e_valid  = edge_rdata[WEIGHT_BITS];
  assign e_w      = edge_rdata[WEIGHT_BITS-1:0];

  // Shared unit: one saturating add and one compare per cycle.
  assign sum = {1'b0, best_q} + (DISTANCE_BITS + 1)'(e_w);
  assign nd  = sum[DISTANCE_BITS] ? DMAX : sum[DISTANCE_BITS-1:0];
  assign relax_upd = pv_q && e_valid && !settled_q[pidx_q] && present_q[pidx_q] &&
                     (!reached_q[pidx_q] || nd < dist_rdata);
  assign find_upd  = pv_q && reached_q[pidx_q] && !settled_q[pidx_q] &&
                     (!have_q || dist_rdata < best_q);

  gspe_ram #(.DW(EDGE_BITS), .AW(EDGE_AW)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  gspe_ram #(.DW(DISTANCE_BITS), .AW(LOG_V)) u_dist (
    .clk_i, .we_i(dist_we), .waddr_i(dist_waddr), .wdata_i(dist_wdata),
    .raddr_i(dist_raddr), .rdata_o(dist_rdata)
  );
  gspe_ram #(.DW(LOG_V), .AW(LOG_V)) u_pred (
    .clk_i, .we_i(pred_we), .waddr_i(pidx_q), .wdata_i(cur_q),
    .raddr_i(curv_q), .rdata_o(pred_rdata)
  );
  gspe_ram #(.DW(LOG_V), .AW(LOG_V)) u_path (
    .clk_i, .we_i(buf_we), .waddr_i(k_q), .wdata_i(curv_q),
    .raddr_i(k_q), .rdata_o(buf_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CNT_BITS'(VERTICES * VERTICES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (mode_q)
          MODE_ADD_EDGE:   state_d = (a_ok && b_ok) ? ST_ADD_WR : ST_IDLE;
          MODE_RMV_VERTEX: state_d = a_ok ? ST_RMV : ST_IDLE;
          MODE_WEIGHT:     state_d = ST_WQ_RES;
          MODE_DISTANCES:  state_d = a_p ? ST_FIND : ST_D_RD;
          MODE_PATH:       state_d = (a_p && b_p) ? ST_FIND : ST_FAIL_RES;
          default:         state_d = ST_IDLE;
        endcase
      end
      ST_ADD_WR: state_d = ST_IDLE;
      ST_RMV: begin
        if (cnt_q == CNT_BITS'(2 * VERTICES - 1)) state_d = ST_IDLE;
      end
      ST_WQ_RES, ST_FAIL_RES: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      ST_FIND: begin
        if (scan_end) state_d = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (!have_q) begin
          if (mode_q == MODE_DISTANCES) state_d = ST_D_RD;
          else state_d = reached_q[bi] ? ST_T_WR : ST_FAIL_RES;
        end else if (mode_q == MODE_PATH && cur_q == bi) begin
          state_d = ST_T_WR;
        end else begin
          state_d = ST_RELAX;
        end
      end
      ST_RELAX: begin
        if (scan_end) state_d = ST_FIND;
      end
      ST_D_RD: state_d = ST_D_OUT;
      ST_D_OUT: begin
        if (res_ready_i) state_d = (ci == LOG_V'(VERTICES - 1)) ? ST_IDLE : ST_D_RD;
      end
      ST_T_WR: begin
        state_d = (curv_q == ai || k_q == LOG_V'(VERTICES - 1)) ? ST_P_RD1 : ST_T_RD;
      end
      ST_T_RD:  state_d = ST_T_WR;
      ST_P_RD1: state_d = ST_P_RD2;
      ST_P_RD2: state_d = ST_P_OUT;
      ST_P_OUT: begin
        if (res_ready_i) state_d = (k_q == '0) ? ST_IDLE : ST_P_RD1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = state_q == ST_IDLE;
    edge_we     = 1'b0;
    edge_waddr  = {ai, bi};
    edge_wdata  = '0;
    edge_raddr  = {ai, bi};
    dist_we     = 1'b0;
    dist_waddr  = pidx_q;
    dist_wdata  = nd;
    dist_raddr  = ci;
    pred_we     = 1'b0;
    buf_we      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_q)
      ST_CLEAR: begin
        edge_we    = 1'b1;
        edge_waddr = cnt_q[EDGE_AW-1:0];
      end
      ST_DISPATCH: begin
        if (mode_q == MODE_RMV_EDGE && a_ok && b_ok) edge_we = 1'b1;
        if ((mode_q == MODE_DISTANCES || mode_q == MODE_PATH) && a_p) begin
          dist_we    = 1'b1;
          dist_waddr = ai;
          dist_wdata = '0;
        end
      end
      ST_ADD_WR: begin
        edge_we    = !e_valid || w_q < e_w;
        edge_wdata = {1'b1, w_q};
      end
      ST_RMV: begin
        edge_we    = 1'b1;
        edge_waddr = cnt_q[LOG_V] ? {ci, ai} : {ai, ci};
      end
      ST_WQ_RES: begin
        res_valid_o      = 1'b1;
        res_o.vertex     = b_q;
        res_o.found      = a_p && e_valid;
        res_o.distance   = (a_p && e_valid) ? DOUT_W'(e_w) : DOUT_W'(DMAX);
        res_o.present    = b_p;
        res_o.last       = 1'b1;
      end
      ST_FAIL_RES: begin
        res_valid_o    = 1'b1;
        res_o.vertex   = b_q;
        res_o.distance = DOUT_W'(DMAX);
        res_o.present  = b_p;
        res_o.last     = 1'b1;
      end
      ST_FIND: edge_raddr = {cur_q, ci};
      ST_RELAX: begin
        edge_raddr = {cur_q, ci};
        dist_we    = relax_upd;
        pred_we    = relax_upd;
      end
      ST_D_OUT: begin
        res_valid_o    = 1'b1;
        res_o.vertex   = SLOT_W'(ci);
        res_o.distance = reached_q[ci] ? DOUT_W'(dist_rdata) : DOUT_W'(DMAX);
        res_o.present  = present_q[ci];
        res_o.found    = reached_q[ci];
        res_o.last     = ci == LOG_V'(VERTICES - 1);
      end
      ST_T_WR: buf_we = 1'b1;
      ST_P_RD2: dist_raddr = buf_rdata;
      ST_P_OUT: begin
        dist_raddr     = v_q;
        res_valid_o    = 1'b1;
        res_o.vertex   = SLOT_W'(v_q);
        res_o.distance = DOUT_W'(dist_rdata);
        res_o.present  = 1'b1;
        res_o.found    = 1'b1;
        res_o.last     = k_q == '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      present_q <= '0;
      reached_q <= '0;
      settled_q <= '0;
      have_q    <= 1'b0;
      pv_q      <= 1'b0;
      mode_q    <= '0;
      a_q       <= '0;
      b_q       <= '0;
      w_q       <= '0;
      cur_q     <= '0;
      pidx_q    <= '0;
      curv_q    <= '0;
      v_q       <= '0;
      k_q       <= '0;
      best_q    <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_CLEAR: cnt_q <= cnt_q + 1'b1;
        ST_IDLE: begin
          mode_q <= in_mode_i;
          a_q    <= in_first_i;
          b_q    <= in_second_i;
          w_q    <= in_weight_i[WEIGHT_BITS-1:0];
          cnt_q  <= '0;
        end
        ST_DISPATCH: begin
          unique case (mode_q)
            MODE_ADD_VERTEX: if (a_ok) present_q[ai] <= 1'b1;
            MODE_RMV_VERTEX: if (a_ok) present_q[ai] <= 1'b0;
            MODE_DISTANCES, MODE_PATH: begin
              reached_q <= a_p ? a_bit : '0;
              settled_q <= '0;
              have_q    <= 1'b0;
              pv_q      <= 1'b0;
            end
            default: ;
          endcase
        end
        ST_ADD_WR: present_q <= present_q | a_bit | b_bit;
        ST_RMV: cnt_q <= cnt_q + 1'b1;
        ST_FIND, ST_RELAX: begin
          pv_q   <= !scan_end;
          pidx_q <= ci;
          cnt_q  <= scan_end ? '0 : cnt_q + 1'b1;
          if (state_q == ST_FIND && find_upd) begin
            cur_q  <= pidx_q;
            best_q <= dist_rdata;
            have_q <= 1'b1;
          end
          if (state_q == ST_RELAX) begin
            if (relax_upd) reached_q[pidx_q] <= 1'b1;
            if (scan_end) have_q <= 1'b0;
          end
        end
        ST_SETTLE: begin
          cnt_q  <= '0;
          pv_q   <= 1'b0;
          curv_q <= bi;
          k_q    <= '0;
          if (have_q) settled_q[cur_q] <= 1'b1;
        end
        ST_D_OUT: if (res_ready_i) cnt_q <= cnt_q + 1'b1;
        ST_T_RD: begin
          curv_q <= pred_rdata;
          k_q    <= k_q + 1'b1;
        end
        ST_P_RD2: v_q <= buf_rdata;
        ST_P_OUT: if (res_ready_i && k_q != '0) k_q <= k_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[sim/tb_graph_shortest_path_engine_top.sv]
// Testbench for graph_shortest_path_engine_top: it sends graph edits and queries, and a
// local Dijkstra predictor checks every result item. Depends on gspe_pkg and the top level.
`timescale 1ns / 100ps

module tb_graph_shortest_path_engine_top;
  import gspe_pkg::*;

  localparam int IDLE_LIMIT = 50000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  graph_shortest_path_engine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic [31:0] cmd_queue[$];
  res_t        expected_results[$];

  bit          edge_on [VERTICES*VERTICES];
  logic [15:0] edge_w  [VERTICES*VERTICES];
  bit          slot_on [VERTICES];
  logic [31:0] route_dist [VERTICES];
  bit          route_done [VERTICES];
  bit          route_seen [VERTICES];
  int          route_prev [VERTICES];

  int cmds_sent    = 0;
  int results_seen = 0;
  int errors       = 0;
  int hold_left    = 0;
  bit hold_used    = 0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] pack_cmd(mode_e m, int a, int b, int w);
    return {1'b0, w[15:0], b[5:0], a[5:0], m};
  endfunction

  function automatic void queue_cmd(logic [31:0] c);
    cmd_queue = {cmd_queue, c};
  endfunction

  function automatic void push_result(int v, logic [31:0] d, bit p, bit f, bit l);
    res_t r;
    r.vertex   = v[5:0];
    r.distance = d;
    r.present  = p;
    r.found    = f;
    r.last     = l;
    expected_results = {expected_results, r};
  endfunction

  function automatic void run_routes(int src, bit stop_at_dst, int dst);
    int cur;
    bit have;
    longint nd;
    for (int i = 0; i < VERTICES; i++) begin
      route_dist[i] = DMAX;
      route_done[i] = 0;
      route_seen[i] = 0;
      route_prev[i] = 0;
    end
    route_dist[src] = 0;
    route_seen[src] = 1;
    for (int r = 0; r < VERTICES; r++) begin
      cur = 0;
      have = 0;
      for (int i = 0; i < VERTICES; i++) begin
        if (route_seen[i] && !route_done[i] && (!have || route_dist[i] < route_dist[cur])) begin
          cur = i;
          have = 1;
        end
      end
      if (!have) break;
      route_done[cur] = 1;
      if (stop_at_dst && cur == dst) break;
      for (int i = 0; i < VERTICES; i++) begin
        if (!edge_on[cur*VERTICES+i] || route_done[i] || !slot_on[i]) continue;
        nd = longint'(route_dist[cur]) + longint'(edge_w[cur*VERTICES+i]);
        if (nd > longint'(DMAX)) nd = longint'(DMAX);
        if (!route_seen[i] || nd < longint'(route_dist[i])) begin
          route_dist[i] = nd[31:0];
          route_prev[i] = cur;
          route_seen[i] = 1;
        end
      end
    end
  endfunction

  function automatic void predict_command(logic [31:0] cmd);
    logic [2:0] m;
    int a, b, n, cur;
    logic [15:0] w;
    int trail[VERTICES];
    m = cmd[2:0];
    a = int'(cmd[8:3]);
    b = int'(cmd[14:9]);
    w = cmd[30:15];
    case (m)
      MODE_ADD_VERTEX: slot_on[a] = 1;
      MODE_ADD_EDGE: begin
        slot_on[a] = 1;
        slot_on[b] = 1;
        if (!edge_on[a*VERTICES+b] || w < edge_w[a*VERTICES+b]) begin
          edge_on[a*VERTICES+b] = 1;
          edge_w[a*VERTICES+b]  = w;
        end
      end
      MODE_RMV_EDGE: edge_on[a*VERTICES+b] = 0;
      MODE_RMV_VERTEX: begin
        slot_on[a] = 0;
        for (int i = 0; i < VERTICES; i++) begin
          edge_on[a*VERTICES+i] = 0;
          edge_on[i*VERTICES+a] = 0;
        end
      end
      MODE_WEIGHT: begin
        if (slot_on[a] && edge_on[a*VERTICES+b])
          push_result(b, {16'd0, edge_w[a*VERTICES+b]}, slot_on[b], 1, 1);
        else
          push_result(b, DMAX, slot_on[b], 0, 1);
      end
      MODE_DISTANCES: begin
        if (slot_on[a]) run_routes(a, 0, 0);
        else for (int i = 0; i < VERTICES; i++) route_seen[i] = 0;
        for (int i = 0; i < VERTICES; i++)
          push_result(i, route_seen[i] ? route_dist[i] : DMAX, slot_on[i], route_seen[i],
                      i == VERTICES - 1);
      end
      MODE_PATH: begin
        if (!slot_on[a] || !slot_on[b]) begin
          push_result(b, DMAX, slot_on[b], 0, 1);
        end else begin
          run_routes(a, 1, b);
          if (!route_seen[b]) begin
            push_result(b, DMAX, 1, 0, 1);
          end else begin
            n = 0;
            cur = b;
            while (n < VERTICES) begin
              trail[n] = cur;
              n++;
              if (cur == a) break;
              cur = route_prev[cur] % VERTICES;
            end
            for (int i = 0; i < n; i++)
              push_result(trail[n-1-i], route_dist[trail[n-1-i]], 1, 1, i == n - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_slot();
    return ($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(63);
  endfunction

  function automatic logic [31:0] random_cmd();
    int r, w;
    mode_e m;
    r = $urandom_range(99);
    if (r < 35)      m = MODE_ADD_EDGE;
    else if (r < 40) m = MODE_ADD_VERTEX;
    else if (r < 49) m = MODE_RMV_EDGE;
    else if (r < 53) m = MODE_RMV_VERTEX;
    else if (r < 68) m = MODE_WEIGHT;
    else if (r < 78) m = MODE_DISTANCES;
    else if (r < 97) m = MODE_PATH;
    else             m = mode_e'(3'd7);
    w = ($urandom_range(99) < 70) ? $urandom_range(40) : $urandom_range(65535);
    return pack_cmd(m, pick_slot(), pick_slot(), w);
  endfunction

  // Stimulus: a directed set of edits and queries, then random traffic.
  initial begin
    rst_ni = 0;
    queue_cmd(pack_cmd(MODE_PATH, 0, 63, 0));
    queue_cmd(pack_cmd(MODE_ADD_VERTEX, 0, 0, 0));
    queue_cmd(pack_cmd(MODE_ADD_VERTEX, 63, 0, 0));
    queue_cmd(pack_cmd(MODE_ADD_EDGE, 0, 63, 65535));
    queue_cmd(pack_cmd(MODE_WEIGHT, 0, 63, 0));
    queue_cmd(pack_cmd(MODE_ADD_EDGE, 0, 63, 5));
    queue_cmd(pack_cmd(MODE_ADD_EDGE, 0, 63, 9));
    queue_cmd(pack_cmd(MODE_ADD_EDGE, 0, 1, 3));
    queue_cmd(pack_cmd(MODE_ADD_EDGE, 1, 2, 0));
    queue_cmd(pack_cmd(MODE_ADD_EDGE, 2, 3, 7));
    queue_cmd(pack_cmd(MODE_ADD_EDGE, 0, 4, 3));
    queue_cmd(pack_cmd(MODE_ADD_EDGE, 4, 3, 7));
    queue_cmd(pack_cmd(MODE_WEIGHT, 0, 63, 0));
    queue_cmd(pack_cmd(MODE_WEIGHT, 5, 1, 0));
    queue_cmd(pack_cmd(MODE_DISTANCES, 0, 0, 0));
    queue_cmd(pack_cmd(MODE_DISTANCES, 5, 0, 0));
    queue_cmd(pack_cmd(MODE_PATH, 0, 3, 0));
    queue_cmd(pack_cmd(MODE_PATH, 0, 0, 0));
    queue_cmd(pack_cmd(MODE_PATH, 63, 0, 0));
    queue_cmd(pack_cmd(MODE_PATH, 0, 10, 0));
    queue_cmd(pack_cmd(MODE_RMV_EDGE, 1, 2, 0));
    queue_cmd(pack_cmd(MODE_RMV_VERTEX, 63, 0, 0));
    queue_cmd(pack_cmd(MODE_WEIGHT, 0, 63, 0));
    queue_cmd(pack_cmd(mode_e'(3'd7), 63, 63, 65535));
    queue_cmd(pack_cmd(MODE_ADD_EDGE, 62, 62, 1));
    queue_cmd(pack_cmd(MODE_DISTANCES, 62, 0, 0));
    for (int i = 0; i < 114; i++) queue_cmd(random_cmd());
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    while (cmd_queue.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d commands covering all modes and checked %0d result items.",
             cmds_sent, results_seen);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_command(s_axis_tdata);
        cmds_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_queue.size() > 0 &&
            ((cmds_sent >= 40 && cmds_sent < 80) || $urandom_range(99) >= 19)) begin
          s_axis_tvalid <= 1;
          s_axis_tdata  <= cmd_queue.pop_front();
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 0;
    end else if (!hold_used && results_seen >= 20) begin
      hold_used = 1;
      hold_left = 600;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= (results_seen >= 100 && results_seen < 300) || $urandom_range(99) >= 19;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h/%b/%b", $time, m_axis_tdata, m_axis_tuser,
                 m_axis_tlast);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[5:0] !== want.vertex) begin
          errors++;
          $display("%0t: vertex expected %0d actual %0d", $time, want.vertex, m_axis_tdata[5:0]);
        end
        if (m_axis_tdata[37:6] !== want.distance) begin
          errors++;
          $display("%0t: distance expected %h actual %h", $time, want.distance,
                   m_axis_tdata[37:6]);
        end
        if (m_axis_tuser[0] !== want.present) begin
          errors++;
          $display("%0t: present expected %b actual %b", $time, want.present, m_axis_tuser[0]);
        end
        if (m_axis_tuser[1] !== want.found) begin
          errors++;
          $display("%0t: found expected %b actual %b", $time, want.found, m_axis_tuser[1]);
        end
        if (m_axis_tlast !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

[sim.f]
hdl/gspe_pkg.sv
hdl/gspe_ram.sv
hdl/gspe_engine.sv
hdl/graph_shortest_path_engine_top.sv
sim/tb_graph_shortest_path_engine_top.sv
